### src/bli_pkg.sv
// Shared types, constants and field layout for the bounded list unit.
package bli_pkg;

    // List geometry: slot indexes, and pointers that also hold the null marker.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

    // Field widths of the stream payloads.
    localparam int VAL_W   = 64;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int IN_RAW_W  = MODE_W + 2 * VAL_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = STAT_W + 1 + COUNT_W + 3 * VAL_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Operation selected by an input transaction.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_HOME    = 2'd1,
        MODE_ADVANCE = 2'd2
    } mode_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_END  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_LINK,
        S_ADV_LINK,
        S_ADV_VAL,
        S_DONE
    } state_t;

    // Access request from the sequencer to the slot store.
    typedef struct packed {
        logic             val_we;
        logic [IDX_W-1:0] val_widx;
        logic [VAL_W-1:0] val_wdata;
        logic             lnk_we;
        logic [IDX_W-1:0] lnk_widx;
        logic [PTR_W-1:0] lnk_wdata;
        logic [IDX_W-1:0] ridx;
    } store_req_t;

endpackage

### src/bli_store.sv
// Slot store: value and link memories with one write port each and a shared registered read.
module bli_store
    import bli_pkg::*;
(
    input  logic             clk,
    input  store_req_t       req,
    output logic [VAL_W-1:0] rd_val,
    output logic [PTR_W-1:0] rd_lnk
);

    logic [VAL_W-1:0] val_mem [CAPACITY];
    logic [PTR_W-1:0] lnk_mem [CAPACITY];

    // Value memory.
    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.val_widx] <= req.val_wdata;
        end
        rd_val <= val_mem[req.ridx];
    end

    // Link memory.
    always_ff @(posedge clk)
    begin
        if (req.lnk_we)
        begin
            lnk_mem[req.lnk_widx] <= req.lnk_wdata;
        end
        rd_lnk <= lnk_mem[req.ridx];
    end

endmodule

### src/bli_feq.sv
// Shared IEEE double equality compare used by the list search.
module bli_feq
    import bli_pkg::*;
(
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output logic             eq
);

    localparam logic [VAL_W-2:0] EXP_ALL = 63'h7FF0_0000_0000_0000;

    logic a_nan;
    logic b_nan;
    logic both_zero;

    // NaN matches nothing; the two zeros match each other.
    always_comb
    begin
        a_nan     = (a[VAL_W-2:0] > EXP_ALL);
        b_nan     = (b[VAL_W-2:0] > EXP_ALL);
        both_zero = (a[VAL_W-2:0] == '0) && (b[VAL_W-2:0] == '0);
        eq        = !a_nan && !b_nan && (both_zero || (a == b));
    end

endmodule

### src/bounded_list_insert_after_cursor_unit.sv
// Top level of the bounded linked list with cursor: sequencer, list registers and result stage.
//
//  Channel   Dir  Fields (low bit first)
//  s_*       in   mode[1:0], after_value[65:2], new_value[129:66], zero pad to 136
//  m_*       out  status[1:0], is_empty[2], entry_count[9:3], first_value[73:10],
//                 last_value[137:74], current_value[201:138], zero pad to 208
//
// An insert into a non-empty list walks the link memory from the head, one entry per cycle
// in S_CMP, and passes through S_LINK when a match is linked in. Advance reads the cursor's
// link in S_ADV_LINK and, unless the cursor is on the tail, the next value in S_ADV_VAL; an
// advance on an empty list and other transactions go straight to S_DONE.
// Reset clears the list registers at once; the memories need no clearing pass.
// A finished result waits in the output register while m_tready is low; a new input
// transaction is taken once the sequencer is idle.
module bounded_list_insert_after_cursor_unit
    import bli_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // mode, after_value, new_value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, is_empty, entry_count, first, last, current
);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] cursor_reg, cursor_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] walk_reg, walk_next;
    logic [VAL_W-1:0] head_val_reg, head_val_next;
    logic [VAL_W-1:0] tail_val_reg, tail_val_next;
    logic [VAL_W-1:0] cur_val_reg, cur_val_next;
    logic [VAL_W-1:0] after_reg, after_next;
    logic [VAL_W-1:0] fresh_reg, fresh_next;
    status_t          status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    store_req_t       req;
    logic [VAL_W-1:0] rd_val;
    logic [PTR_W-1:0] rd_lnk;
    logic             match;

    logic             in_acc;
    mode_t            in_mode;
    logic [VAL_W-1:0] in_after;
    logic [VAL_W-1:0] in_fresh;
    logic [IDX_W-1:0] slot_idx;
    logic             empty;

    // Payload fields of the input transaction.
    assign in_mode  = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_after = s_tdata[MODE_W +: VAL_W];
    assign in_fresh = s_tdata[MODE_W + VAL_W +: VAL_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign slot_idx = count_reg[IDX_W-1:0];
    assign empty    = (count_reg == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bli_store u_store (
        .clk    (clk),
        .req    (req),
        .rd_val (rd_val),
        .rd_lnk (rd_lnk)
    );

    bli_feq u_feq (
        .a  (rd_val),
        .b  (after_reg),
        .eq (match)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // List control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_PTR;
            tail_reg      <= NULL_PTR;
            cursor_reg    <= NULL_PTR;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        walk_reg     <= walk_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
        cur_val_reg  <= cur_val_next;
        after_reg    <= after_next;
        fresh_reg    <= fresh_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: next state, list updates and store requests.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        head_val_next  = head_val_reg;
        tail_val_next  = tail_val_reg;
        cur_val_next   = cur_val_reg;
        after_next     = after_reg;
        fresh_next     = fresh_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        req.val_we    = 1'b0;
        req.val_widx  = slot_idx;
        req.val_wdata = in_fresh;
        req.lnk_we    = 1'b0;
        req.lnk_widx  = slot_idx;
        req.lnk_wdata = head_reg;
        req.ridx      = walk_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                // Start the first read before the transaction is even seen.
                if (in_mode == MODE_INSERT)
                begin
                    req.ridx = head_reg[IDX_W-1:0];
                end
                else
                begin
                    req.ridx = cursor_reg[IDX_W-1:0];
                end
                if (in_acc)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            if (count_reg >= PTR_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                req.val_we = 1'b1;
                                after_next = in_after;
                                fresh_next = in_fresh;
                                walk_next  = head_reg;
                                if (head_reg == NULL_PTR)
                                begin
                                    // Empty list: the new entry is head and tail.
                                    req.lnk_we    = 1'b1;
                                    head_next     = count_reg;
                                    head_val_next = in_fresh;
                                    tail_next     = count_reg;
                                    tail_val_next = in_fresh;
                                    cursor_next   = count_reg;
                                    cur_val_next  = in_fresh;
                                    count_next    = count_reg + 1'b1;
                                end
                                else
                                begin
                                    state_next = S_CMP;
                                end
                            end
                        end
                        MODE_HOME:
                        begin
                            cursor_next  = head_reg;
                            cur_val_next = head_val_reg;
                        end
                        MODE_ADVANCE:
                        begin
                            if (cursor_reg == NULL_PTR)
                            begin
                                status_next = ST_END;
                            end
                            else
                            begin
                                state_next = S_ADV_LINK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                // One entry of the search per cycle.
                if (match)
                begin
                    req.lnk_we    = 1'b1;
                    req.lnk_wdata = rd_lnk;
                    state_next    = S_LINK;
                end
                else if (rd_lnk == NULL_PTR)
                begin
                    // No match: the new entry goes in front of the head.
                    req.lnk_we    = 1'b1;
                    req.lnk_wdata = head_reg;
                    head_next     = count_reg;
                    head_val_next = fresh_reg;
                    cursor_next   = count_reg;
                    cur_val_next  = fresh_reg;
                    count_next    = count_reg + 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    walk_next = rd_lnk;
                    req.ridx  = rd_lnk[IDX_W-1:0];
                end
            end
            S_LINK:
            begin
                // Point the matched entry at the new one.
                req.lnk_we    = 1'b1;
                req.lnk_widx  = walk_reg[IDX_W-1:0];
                req.lnk_wdata = count_reg;
                if (walk_reg == tail_reg)
                begin
                    tail_next     = count_reg;
                    tail_val_next = fresh_reg;
                end
                cursor_next  = count_reg;
                cur_val_next = fresh_reg;
                count_next   = count_reg + 1'b1;
                state_next   = S_DONE;
            end
            S_ADV_LINK:
            begin
                if (rd_lnk == NULL_PTR)
                begin
                    status_next = ST_END;
                    state_next  = S_DONE;
                end
                else
                begin
                    cursor_next = rd_lnk;
                    req.ridx    = rd_lnk[IDX_W-1:0];
                    state_next  = S_ADV_VAL;
                end
            end
            S_ADV_VAL:
            begin
                cur_val_next = rd_val;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        (OUT_W - OUT_RAW_W)'(0),
                        empty ? {VAL_W{1'b0}} : cur_val_reg,
                        empty ? {VAL_W{1'b0}} : tail_val_reg,
                        empty ? {VAL_W{1'b0}} : head_val_reg,
                        COUNT_W'(count_reg),
                        empty,
                        status_reg
                    };
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/bli_chk.sv
// Port-level checker for the bounded list unit, bound to the top level.
module bli_chk
    import bli_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The entry count never exceeds the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9:3] <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == (m_tdata[9:3] == '0)))
        else $error("empty flag disagrees with count");

    // An empty list reports zero values.
    a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[201:10] == '0)
        else $error("empty list reports values");

    // An accepted input transaction leaves the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind bounded_list_insert_after_cursor_unit bli_chk u_bli_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
